// File: rtl/core/vertex_mvp_transform_macros.svh
// assertion helpers for the vertex transform
`ifndef VERTEX_MVP_TRANSFORM_MACROS_SVH
`define VERTEX_MVP_TRANSFORM_MACROS_SVH

// same-cycle implication, idle during reset
`define VMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define VMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/vmt_pkg.sv
`timescale 1ns / 1ps

package vmt_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHIFT_W + 2;
  localparam int DIM       = 4;
  localparam int MAT_COUNT = 3;
  localparam int IDX_W     = 2;
  localparam int MAT_SEL_W = 2;

  // mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [DIM-1:0] vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // one in four homogeneous coordinate
  localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

  // saturation bounds at sum width
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  // load item fields carried down the pipe
  typedef struct packed {
    logic                 is_load;
    logic [MAT_SEL_W-1:0] which;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    word_t                value;
  } meta_t;

  // product floored to the fraction point
  function automatic logic signed [SHIFT_W-1:0] floor_shift(input prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    return SHIFT_W'(s);
  endfunction

  // clamp a row sum to the data range
  function automatic word_t sat_sum(input logic signed [SUM_W-1:0] s);
    word_t r;
    if (s > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (s < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/vertex_mvp_transform.sv
`timescale 1ns / 1ps
// Model-view-projection vertex transform in signed fixed point (Q16.16).
// A load item (mode 0) writes one entry of the model, view or projection
// matrix and gives no result; a load with matrix selector three is dropped.
// A vertex item (mode 1) takes (x, y, z, 1.0) through model, view and
// projection in turn and gives one result of four clip coordinates. Each
// matrix pass is two register stages: sixteen 32x32 multipliers, then the
// floored row sums with saturation. One item enters per clock while in_ready
// is high, and passes the three multiply and three sum stages. A load takes
// effect as it passes its matrix's multiply stage, so every vertex sees
// exactly the loads that came before it. All matrices are zero after reset,
// with no clearing pass.

`include "vertex_mvp_transform_macros.svh"

module vertex_mvp_transform
  import vmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [MAT_SEL_W-1:0] which_matrix,
  input  logic [IDX_W-1:0]     row,
  input  logic [IDX_W-1:0]     col,
  input  logic signed [31:0]   entry_value,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   clip_x,
  output logic signed [31:0]   clip_y,
  output logic signed [31:0]   clip_z,
  output logic signed [31:0]   clip_w
);

  // stage entry of each matrix pass
  logic  ent_v    [MAT_COUNT];
  meta_t ent_meta [MAT_COUNT];
  vec_t  ent_vec  [MAT_COUNT];

  // multiply stages
  logic  mul_v    [MAT_COUNT];
  logic  mul_rdy  [MAT_COUNT];
  meta_t mul_meta [MAT_COUNT];

  // sum stages, the last one is the output register
  logic  sum_v    [MAT_COUNT];
  logic  sum_rdy  [MAT_COUNT];
  meta_t sum_meta [MAT_COUNT-1];
  vec_t  sum_vec  [MAT_COUNT];

  genvar k;
  generate
    for (k = 0; k < MAT_COUNT; k++) begin : g_pass
      word_t mat  [DIM][DIM];
      prod_t prod [DIM][DIM];

      // where items come from
      if (k == 0) begin : g_src_in
        assign ent_v[k]            = in_valid;
        assign ent_meta[k].is_load = (mode == MODE_LOAD);
        assign ent_meta[k].which   = which_matrix;
        assign ent_meta[k].row     = row;
        assign ent_meta[k].col     = col;
        assign ent_meta[k].value   = entry_value;
        assign ent_vec[k]          = {ONE, pos_z, pos_y, pos_x};
      end else begin : g_src_prev
        assign ent_v[k]    = sum_v[k-1];
        assign ent_meta[k] = sum_meta[k-1];
        assign ent_vec[k]  = sum_vec[k-1];
      end

      // ready chain
      assign mul_rdy[k] = !mul_v[k] || sum_rdy[k];
      if (k == MAT_COUNT - 1) begin : g_rdy_out
        assign sum_rdy[k] = !sum_v[k] || out_ready;
      end else begin : g_rdy_mid
        assign sum_rdy[k] = !sum_v[k] || mul_rdy[k+1];
      end

      // matrix entries, written as a load passes this multiply stage
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
              mat[r][c] <= '0;
            end
          end
        end else if (mul_rdy[k] && ent_v[k] && ent_meta[k].is_load &&
                     ent_meta[k].which == MAT_SEL_W'(k)) begin
          mat[ent_meta[k].row][ent_meta[k].col] <= ent_meta[k].value;
        end
      end

      // multiply stage valid
      always_ff @(posedge clk) begin
        if (rst) begin
          mul_v[k] <= 1'b0;
        end else if (mul_rdy[k]) begin
          mul_v[k] <= ent_v[k];
        end
      end

      // full-width products
      always_ff @(posedge clk) begin
        if (mul_rdy[k] && ent_v[k]) begin
          mul_meta[k] <= ent_meta[k];
          for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
              prod[r][c] <= mat[r][c] * ent_vec[k][c];
            end
          end
        end
      end

      // sum stage valid, loads leave after the last matrix
      always_ff @(posedge clk) begin
        if (rst) begin
          sum_v[k] <= 1'b0;
        end else if (sum_rdy[k]) begin
          if (k == MAT_COUNT - 1) begin
            sum_v[k] <= mul_v[k] && !mul_meta[k].is_load;
          end else begin
            sum_v[k] <= mul_v[k];
          end
        end
      end

      // floored row sums with saturation
      always_ff @(posedge clk) begin
        if (sum_rdy[k] && mul_v[k]) begin
          for (int r = 0; r < DIM; r++) begin
            sum_vec[k][r] <= sat_sum(SUM_W'(floor_shift(prod[r][0])) +
                                     SUM_W'(floor_shift(prod[r][1])) +
                                     SUM_W'(floor_shift(prod[r][2])) +
                                     SUM_W'(floor_shift(prod[r][3])));
          end
        end
      end

      // item fields for the next pass
      if (k < MAT_COUNT - 1) begin : g_meta
        always_ff @(posedge clk) begin
          if (sum_rdy[k] && mul_v[k]) begin
            sum_meta[k] <= mul_meta[k];
          end
        end
      end
    end
  endgenerate

  // ports
  assign in_ready  = mul_rdy[0];
  assign out_valid = sum_v[MAT_COUNT-1];
  assign clip_x    = sum_vec[MAT_COUNT-1][0];
  assign clip_y    = sum_vec[MAT_COUNT-1][1];
  assign clip_z    = sum_vec[MAT_COUNT-1][2];
  assign clip_w    = sum_vec[MAT_COUNT-1][3];

  // checks
  `VMT_ASSERT_SAME(a_ready_only_when_full, !in_ready, mul_v[0] && sum_v[0], "input blocked with a free stage")
  `VMT_ASSERT_NEXT(a_stall_keeps_item, mul_v[0] && !sum_rdy[0], mul_v[0], "stalled item lost in multiply stage")
  `VMT_ASSERT_NEXT(a_load_gives_no_result, mul_v[2] && mul_meta[2].is_load && sum_rdy[2], !out_valid, "load item reached the output")

endmodule
